[rtl/vgrt_pkg.sv]
// ---------------------------------------------------------------------------
// vgrt_pkg: shared constants, codes and types
// Grid geometry, item and status codes, controller/datapath interface.
// ---------------------------------------------------------------------------
package vgrt_pkg;

   localparam int CHUNK_SIDE = 16;
   localparam int GRID_SIDE  = 4;
   localparam int CHUNK_BITS = $clog2(CHUNK_SIDE);
   localparam int GRID_BITS  = $clog2(GRID_SIDE);
   localparam int WIN_BITS   = CHUNK_BITS + GRID_BITS;
   localparam int NCHUNK     = GRID_SIDE * GRID_SIDE * GRID_SIDE;
   localparam int CI_W       = 3 * GRID_BITS;
   localparam int ADDR_W     = 3 * WIN_BITS;
   localparam int DEPTH      = 1 << ADDR_W;
   localparam int CELL_W     = 18;
   localparam int REL_W      = CELL_W + 1;
   localparam int TM_W       = 33;
   localparam logic [TM_W-1:0] T_INF = {1'b1, {(TM_W-1){1'b0}}};

   localparam logic [1:0] KIND_WRITE = 2'd0;
   localparam logic [1:0] KIND_LOAD  = 2'd1;
   localparam logic [1:0] KIND_RAY   = 2'd2;

   localparam logic [1:0] ST_HIT  = 2'd0;
   localparam logic [1:0] ST_OUT  = 2'd1;
   localparam logic [1:0] ST_MAXD = 2'd2;

   localparam logic [1:0] AX_NONE = 2'd0;

   localparam logic [1:0] CSR_ORG_X = 2'd0;
   localparam logic [1:0] CSR_ORG_Y = 2'd1;
   localparam logic [1:0] CSR_ORG_Z = 2'd2;

   // divider jobs: three reciprocals, then three first boundaries
   localparam logic [2:0] DIV_LAST = 3'd5;

   typedef struct packed {
      logic       accept;
      logic       clear;
      logic       wr_voxel;
      logic       wr_load;
      logic       div_start;
      logic       div_take;
      logic [2:0] div_sel;
      logic       look;
      logic       check;
      logic       end_mul;
      logic       end_add;
      logic [1:0] end_axis;
   } vgrt_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic div_done;
      logic stop;
   } vgrt_sts_type;

endpackage

[rtl/vgrt_ram.sv]
// ---------------------------------------------------------------------------
// vgrt_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ---------------------------------------------------------------------------
module vgrt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

[rtl/vgrt_div.sv]
// ---------------------------------------------------------------------------
// vgrt_div: iterative unsigned divider
// 32-bit dividend by 16-bit divisor, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module vgrt_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [15:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);

   logic [31:0] quo_ff, quo_in;
   logic [15:0] rem_ff, rem_in;
   logic [15:0] dvs_ff;
   logic [4:0]  cnt_ff;
   logic        run_ff;
   logic        done_ff;
   logic [16:0] trial;
   logic [16:0] diff;

   always_comb begin
      trial = {rem_ff, quo_ff[31]};
      diff  = trial - {1'b0, dvs_ff};
      if (trial >= {1'b0, dvs_ff}) begin
         rem_in = diff[15:0];
         quo_in = {quo_ff[30:0], 1'b1};
      end else begin
         rem_in = trial[15:0];
         quo_in = {quo_ff[30:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= run_ff && (cnt_ff == 5'd31);
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               run_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (run_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[rtl/vgrt_datapath.sv]
// ---------------------------------------------------------------------------
// vgrt_datapath: voxel store, chunk bits and DDA walk registers
// Locates cells in the window, runs the divider setup, steps the walk and
// forms the end point.
// ---------------------------------------------------------------------------
module vgrt_datapath import vgrt_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  vgrt_cmd_type        cmd,
   output vgrt_sts_type        sts,
   input  logic signed [31:0]  req_pos_x,
   input  logic signed [31:0]  req_pos_y,
   input  logic signed [31:0]  req_pos_z,
   input  logic signed [15:0]  req_dir_x,
   input  logic signed [15:0]  req_dir_y,
   input  logic signed [15:0]  req_dir_z,
   input  logic [30:0]         req_max_distance,
   input  logic [7:0]          req_voxel_value,
   input  logic                req_loaded_flag,
   input  logic                csr_write,
   input  logic [1:0]          csr_index,
   input  logic [11:0]         csr_wdata,
   output logic [1:0]          rsp_status,
   output logic [7:0]          rsp_hit_value,
   output logic signed [15:0]  rsp_cell_x,
   output logic signed [15:0]  rsp_cell_y,
   output logic signed [15:0]  rsp_cell_z,
   output logic [1:0]          rsp_normal_axis,
   output logic                rsp_normal_negative,
   output logic signed [31:0]  rsp_end_x,
   output logic signed [31:0]  rsp_end_y,
   output logic signed [31:0]  rsp_end_z,
   output logic [30:0]         rsp_ray_param
);

   logic signed [11:0]     org_ff [3];
   logic signed [31:0]     pos_ff [3];
   logic signed [15:0]     dir_ff [3];
   logic signed [CELL_W-1:0] cell_ff [3];
   logic [TM_W-1:0]        tmax_ff [3];
   logic [31:0]            delta_ff [3];
   logic signed [31:0]     end_ff [3];
   logic [30:0]            maxd_ff;
   logic [7:0]             val_ff;
   logic                   flag_ff;
   logic [30:0]            t_ff;
   logic [1:0]             last_ff;
   logic                   neg_ff;
   logic [1:0]             status_ff;
   logic [7:0]             hit_ff;
   logic                   inside_ff;
   logic                   loaded_ff;
   logic [ADDR_W-1:0]      clr_ff;
   logic [NCHUNK-1:0]      chunk_ld_ff;
   logic signed [47:0]     prod_ff;

   logic signed [31:0]     req_pos [3];
   logic signed [15:0]     req_dir [3];
   logic signed [REL_W-1:0] rel [3];
   logic [2:0]             in_win;
   logic                   in_window;
   logic [CI_W-1:0]        ci;
   logic [ADDR_W-1:0]      cell_addr;
   logic [ADDR_W-1:0]      ram_addr;
   logic                   ram_we;
   logic [7:0]             ram_wdata;
   logic [7:0]             ram_rdata;

   logic [1:0]             div_ax;
   logic [15:0]            mag;
   logic [16:0]            bnd_dist;
   logic [31:0]            dividend;
   logic                   div_done;
   logic [31:0]            quotient;

   logic [1:0]             ax;
   logic                   too_far;
   logic signed [32:0]     scaled;
   logic signed [33:0]     end_sum;

   assign req_pos[0] = req_pos_x;
   assign req_pos[1] = req_pos_y;
   assign req_pos[2] = req_pos_z;
   assign req_dir[0] = req_dir_x;
   assign req_dir[1] = req_dir_y;
   assign req_dir[2] = req_dir_z;

   // window lookup of the current cell
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         rel[a] = REL_W'(cell_ff[a]) - (REL_W'(org_ff[a]) <<< CHUNK_BITS);
         in_win[a] = (rel[a][REL_W-1:WIN_BITS] == '0);
      end
      in_window = &in_win;
      ci = {rel[1][WIN_BITS-1:CHUNK_BITS], rel[2][WIN_BITS-1:CHUNK_BITS],
            rel[0][WIN_BITS-1:CHUNK_BITS]};
      cell_addr = {ci, rel[1][CHUNK_BITS-1:0], rel[2][CHUNK_BITS-1:0],
                   rel[0][CHUNK_BITS-1:0]};
   end

   always_comb begin
      ram_addr  = cmd.clear ? clr_ff : cell_addr;
      ram_we    = cmd.clear || (cmd.wr_voxel && in_window && chunk_ld_ff[ci]);
      ram_wdata = cmd.clear ? 8'd0 : val_ff;
   end

   vgrt_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // divider operands for the selected job
   always_comb begin
      div_ax = (cmd.div_sel < 3'd3) ? cmd.div_sel[1:0] : 2'(cmd.div_sel - 3'd3);
      mag = dir_ff[div_ax][15] ? 16'(-dir_ff[div_ax]) : 16'(dir_ff[div_ax]);
      if (dir_ff[div_ax] > 16'sd0) begin
         bnd_dist = 17'h10000 - {1'b0, pos_ff[div_ax][15:0]};
      end else begin
         bnd_dist = {1'b0, pos_ff[div_ax][15:0]};
      end
      dividend = (cmd.div_sel < 3'd3) ? 32'h8000_0000 : {bnd_dist, 15'd0};
   end

   vgrt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (mag),
      .done     (div_done),
      .quotient (quotient)
   );

   // smallest boundary, ties to z then y
   always_comb begin
      if (tmax_ff[0] < tmax_ff[1]) begin
         ax = (tmax_ff[0] < tmax_ff[2]) ? 2'd0 : 2'd2;
      end else begin
         ax = (tmax_ff[1] < tmax_ff[2]) ? 2'd1 : 2'd2;
      end
      too_far = tmax_ff[ax] > TM_W'(maxd_ff);
   end

   always_comb begin
      scaled  = 33'(prod_ff >>> 15);
      end_sum = 34'(pos_ff[cmd.end_axis]) + 34'(scaled);
   end

   assign sts.clear_done = (clr_ff == '1);
   assign sts.div_done   = div_done;
   assign sts.stop       = !inside_ff || !loaded_ff || (ram_rdata != 8'd0) || too_far;

   // control-side state: window origin, chunk bits, clear sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < 3; a++) begin
            org_ff[a] <= '0;
         end
         chunk_ld_ff <= '0;
         clr_ff      <= '0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_ORG_X: org_ff[0] <= csr_wdata;
               CSR_ORG_Y: org_ff[1] <= csr_wdata;
               CSR_ORG_Z: org_ff[2] <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.wr_load && in_window) begin
            chunk_ld_ff[ci] <= flag_ff;
         end
         if (cmd.clear) begin
            clr_ff <= clr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         for (int a = 0; a < 3; a++) begin
            pos_ff[a]  <= req_pos[a];
            dir_ff[a]  <= req_dir[a];
            cell_ff[a] <= CELL_W'($signed(req_pos[a][31:16]));
         end
         maxd_ff <= req_max_distance;
         val_ff  <= req_voxel_value;
         flag_ff <= req_loaded_flag;
         t_ff    <= '0;
         last_ff <= AX_NONE;
         neg_ff  <= 1'b0;
      end
      if (cmd.div_take) begin
         if (cmd.div_sel < 3'd3) begin
            delta_ff[div_ax] <= quotient;
         end else begin
            tmax_ff[div_ax] <= (mag == 16'd0) ? T_INF : TM_W'(quotient);
         end
      end
      if (cmd.look) begin
         inside_ff <= in_window;
         loaded_ff <= chunk_ld_ff[ci];
      end
      if (cmd.check) begin
         priority if (!inside_ff || !loaded_ff) begin
            status_ff <= ST_OUT;
            hit_ff    <= 8'd0;
         end else if (ram_rdata != 8'd0) begin
            status_ff <= ST_HIT;
            hit_ff    <= ram_rdata;
         end else if (too_far) begin
            status_ff <= ST_MAXD;
            hit_ff    <= 8'd0;
            t_ff      <= maxd_ff;
            last_ff   <= AX_NONE;
            neg_ff    <= 1'b0;
         end else begin
            cell_ff[ax]  <= (dir_ff[ax] > 16'sd0) ? cell_ff[ax] + 1'b1
                                                  : cell_ff[ax] - 1'b1;
            t_ff         <= tmax_ff[ax][30:0];
            tmax_ff[ax]  <= tmax_ff[ax] + TM_W'(delta_ff[ax]);
            last_ff      <= 2'(ax + 2'd1);
            neg_ff       <= (dir_ff[ax] > 16'sd0);
         end
      end
      if (cmd.end_mul) begin
         prod_ff <= $signed({17'd0, t_ff}) * 48'(dir_ff[cmd.end_axis]);
      end
      if (cmd.end_add) begin
         // saturate to the 32-bit signed range
         if (end_sum[33:31] == 3'b000 || end_sum[33:31] == 3'b111) begin
            end_ff[cmd.end_axis] <= end_sum[31:0];
         end else if (end_sum[33]) begin
            end_ff[cmd.end_axis] <= 32'sh8000_0000;
         end else begin
            end_ff[cmd.end_axis] <= 32'sh7FFF_FFFF;
         end
      end
   end

   assign rsp_status          = status_ff;
   assign rsp_hit_value       = hit_ff;
   assign rsp_cell_x          = cell_ff[0][15:0];
   assign rsp_cell_y          = cell_ff[1][15:0];
   assign rsp_cell_z          = cell_ff[2][15:0];
   assign rsp_normal_axis     = last_ff;
   assign rsp_normal_negative = neg_ff;
   assign rsp_end_x           = end_ff[0];
   assign rsp_end_y           = end_ff[1];
   assign rsp_end_z           = end_ff[2];
   assign rsp_ray_param       = t_ff;

endmodule

[rtl/vgrt_ctrl.sv]
// ---------------------------------------------------------------------------
// vgrt_ctrl: sequencer
// Clears the store after reset, dispatches items and steps the ray walk.
// ---------------------------------------------------------------------------
module vgrt_ctrl import vgrt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [1:0]   req_kind,
   input  vgrt_sts_type sts,
   output vgrt_cmd_type cmd,
   output logic         busy,
   output logic         rsp_valid
);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_WRITE, S_LOAD, S_DIV_GO, S_DIV_WAIT,
      S_LOOK, S_CHECK, S_MUL, S_ADD, S_RSP
   } state_type;

   state_type  state_ff;
   logic [2:0] sel_ff;
   logic [1:0] axis_ff;
   logic       busy_ff;
   logic       rsp_valid_ff;

   always_comb begin
      cmd           = '0;
      cmd.div_sel   = sel_ff;
      cmd.end_axis  = axis_ff;
      cmd.accept    = (state_ff == S_IDLE) && start;
      cmd.clear     = (state_ff == S_CLEAR);
      cmd.wr_voxel  = (state_ff == S_WRITE);
      cmd.wr_load   = (state_ff == S_LOAD);
      cmd.div_start = (state_ff == S_DIV_GO);
      cmd.div_take  = (state_ff == S_DIV_WAIT) && sts.div_done;
      cmd.look      = (state_ff == S_LOOK);
      cmd.check     = (state_ff == S_CHECK);
      cmd.end_mul   = (state_ff == S_MUL);
      cmd.end_add   = (state_ff == S_ADD);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         sel_ff       <= '0;
         axis_ff      <= '0;
         busy_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_CLEAR: begin
               if (sts.clear_done) begin
                  state_ff <= S_IDLE;
                  busy_ff  <= 1'b0;
               end
            end
            S_IDLE: begin
               if (start) begin
                  priority case (req_kind)
                     KIND_WRITE: begin
                        state_ff <= S_WRITE;
                        busy_ff  <= 1'b1;
                     end
                     KIND_LOAD: begin
                        state_ff <= S_LOAD;
                        busy_ff  <= 1'b1;
                     end
                     KIND_RAY: begin
                        state_ff <= S_DIV_GO;
                        sel_ff   <= '0;
                        busy_ff  <= 1'b1;
                     end
                     default: ;
                  endcase
               end
            end
            S_WRITE, S_LOAD: begin
               state_ff <= S_IDLE;
               busy_ff  <= 1'b0;
            end
            S_DIV_GO: state_ff <= S_DIV_WAIT;
            S_DIV_WAIT: begin
               if (sts.div_done) begin
                  if (sel_ff == DIV_LAST) begin
                     state_ff <= S_LOOK;
                  end else begin
                     sel_ff   <= sel_ff + 3'd1;
                     state_ff <= S_DIV_GO;
                  end
               end
            end
            S_LOOK: state_ff <= S_CHECK;
            S_CHECK: begin
               if (sts.stop) begin
                  state_ff <= S_MUL;
                  axis_ff  <= '0;
               end else begin
                  state_ff <= S_LOOK;
               end
            end
            S_MUL: state_ff <= S_ADD;
            S_ADD: begin
               if (axis_ff == 2'd2) begin
                  state_ff     <= S_RSP;
                  rsp_valid_ff <= 1'b1;
               end else begin
                  axis_ff  <= axis_ff + 2'd1;
                  state_ff <= S_MUL;
               end
            end
            S_RSP: begin
               state_ff <= S_IDLE;
               busy_ff  <= 1'b0;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

[rtl/voxel_grid_ray_traversal.sv]
// Writes and load-bit updates are done in the S_WRITE and S_LOAD states; a ray
// runs its setup as six jobs in one shared 32-step divider, then reads the
// store once per cell visited, then forms the end point and delivers the word.
// One item at a time; busy stays high until the word is delivered.
// Reset: synchronous; it runs a clearing pass over the voxel store with busy
// high; configuration writes are taken throughout.
// ---------------------------------------------------------------------------
// voxel_grid_ray_traversal: top level
// Voxel store with per-chunk loaded bits and a fixed-point 3D DDA walker.
// ---------------------------------------------------------------------------
module voxel_grid_ray_traversal import vgrt_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_kind,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic signed [15:0] req_dir_x,
   input  logic signed [15:0] req_dir_y,
   input  logic signed [15:0] req_dir_z,
   input  logic [30:0]        req_max_distance,
   input  logic [7:0]         req_voxel_value,
   input  logic               req_loaded_flag,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic [7:0]         rsp_hit_value,
   output logic signed [15:0] rsp_cell_x,
   output logic signed [15:0] rsp_cell_y,
   output logic signed [15:0] rsp_cell_z,
   output logic [1:0]         rsp_normal_axis,
   output logic               rsp_normal_negative,
   output logic signed [31:0] rsp_end_x,
   output logic signed [31:0] rsp_end_y,
   output logic signed [31:0] rsp_end_z,
   output logic [30:0]        rsp_ray_param,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [11:0]        csr_wdata
);

   vgrt_cmd_type cmd;
   vgrt_sts_type sts;

   assign csr_ready = 1'b1;

   vgrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_kind  (req_kind),
      .sts       (sts),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   vgrt_datapath u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_pos_x           (req_pos_x),
      .req_pos_y           (req_pos_y),
      .req_pos_z           (req_pos_z),
      .req_dir_x           (req_dir_x),
      .req_dir_y           (req_dir_y),
      .req_dir_z           (req_dir_z),
      .req_max_distance    (req_max_distance),
      .req_voxel_value     (req_voxel_value),
      .req_loaded_flag     (req_loaded_flag),
      .csr_write           (csr_valid && csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .rsp_status          (rsp_status),
      .rsp_hit_value       (rsp_hit_value),
      .rsp_cell_x          (rsp_cell_x),
      .rsp_cell_y          (rsp_cell_y),
      .rsp_cell_z          (rsp_cell_z),
      .rsp_normal_axis     (rsp_normal_axis),
      .rsp_normal_negative (rsp_normal_negative),
      .rsp_end_x           (rsp_end_x),
      .rsp_end_y           (rsp_end_y),
      .rsp_end_z           (rsp_end_z),
      .rsp_ray_param       (rsp_ray_param)
   );

endmodule

[rtl/vgrt_checker.sv]
// ---------------------------------------------------------------------------
// vgrt_checker: port-level checks
// Result word framing and consistency of the result fields.
// ---------------------------------------------------------------------------
module vgrt_checker import vgrt_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       busy,
   input logic       rsp_valid,
   input logic [1:0] rsp_status,
   input logic [7:0] rsp_hit_value,
   input logic [1:0] rsp_normal_axis
);

   a_strobe_one_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_valid_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result word while not busy");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_HIT || rsp_status == ST_OUT ||
                     rsp_status == ST_MAXD))
      else $error("bad status code");

   a_hit_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_status == ST_HIT) == (rsp_hit_value != 8'd0)))
      else $error("hit value does not match status");

   a_maxd_normal: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_MAXD) |-> (rsp_normal_axis == AX_NONE))
      else $error("normal set on max distance stop");

endmodule

bind voxel_grid_ray_traversal vgrt_checker u_vgrt_checker (
   .clock           (clock),
   .reset           (reset),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_status      (rsp_status),
   .rsp_hit_value   (rsp_hit_value),
   .rsp_normal_axis (rsp_normal_axis)
);

[sim/voxel_grid_ray_traversal_chk.sv]
// ---------------------------------------------------------------------------
// voxel_grid_ray_traversal_chk: result checker
// Mirrors the voxel store, chunk loaded bits and window origin, walks each
// accepted ray with a fixed-point 3D DDA and compares every result word.
// ---------------------------------------------------------------------------
module voxel_grid_ray_traversal_chk import vgrt_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [1:0]         req_kind,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic signed [15:0] req_dir_x,
   input  logic signed [15:0] req_dir_y,
   input  logic signed [15:0] req_dir_z,
   input  logic [30:0]        req_max_distance,
   input  logic [7:0]         req_voxel_value,
   input  logic               req_loaded_flag,
   input  logic               rsp_valid,
   input  logic [1:0]         rsp_status,
   input  logic [7:0]         rsp_hit_value,
   input  logic [15:0]        rsp_cell_x,
   input  logic [15:0]        rsp_cell_y,
   input  logic [15:0]        rsp_cell_z,
   input  logic [1:0]         rsp_normal_axis,
   input  logic               rsp_normal_negative,
   input  logic [31:0]        rsp_end_x,
   input  logic [31:0]        rsp_end_y,
   input  logic [31:0]        rsp_end_z,
   input  logic [30:0]        rsp_ray_param,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [11:0]        csr_wdata,
   output int                 fail_count,
   output int                 pending
);

   localparam logic [1:0] AX_X = 2'd1;
   localparam logic [1:0] AX_Y = 2'd2;
   localparam logic [1:0] AX_Z = 2'd3;
   localparam longint T_NEVER = 64'sd1 <<< 62;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  hit;
      logic [15:0] cx, cy, cz;
      logic [1:0]  axis;
      logic        neg;
      logic [31:0] ex, ey, ez;
      logic [30:0] t;
   } ray_word_type;

   logic [7:0]   voxel_mem [DEPTH];
   logic         chunk_on [NCHUNK];
   longint       org [3];
   ray_word_type ray_q [$];

   initial begin
      fail_count = 0;
      for (int i = 0; i < DEPTH; i++) voxel_mem[i] = 8'd0;
      for (int i = 0; i < NCHUNK; i++) chunk_on[i] = 1'b0;
      for (int a = 0; a < 3; a++) org[a] = 0;
   end

   assign pending = ray_q.size();

   // Map a cell to chunk and store address; 0 when outside the window.
   function automatic bit find_cell(input longint cx, cy, cz, output int ci, output int addr);
      longint c [3];
      longint ch [3];
      longint lo [3];
      longint rel;
      int     vi;
      c[0] = cx; c[1] = cy; c[2] = cz;
      ci = 0; addr = 0;
      for (int a = 0; a < 3; a++) begin
         rel = c[a] - org[a] * CHUNK_SIDE;
         ch[a] = rel >>> CHUNK_BITS;
         if (ch[a] < 0 || ch[a] >= GRID_SIDE) return 0;
         lo[a] = rel - ch[a] * CHUNK_SIDE;
      end
      ci = int'((ch[1] * GRID_SIDE + ch[2]) * GRID_SIDE + ch[0]);
      vi = int'((lo[1] * CHUNK_SIDE + lo[2]) * CHUNK_SIDE + lo[0]);
      addr = ci * CHUNK_SIDE * CHUNK_SIDE * CHUNK_SIDE + vi;
      return 1;
   endfunction

   function automatic ray_word_type walk_ray(input longint px, py, pz, dx, dy, dz,
                                             input longint maxd);
      ray_word_type w;
      longint p [3];
      longint d [3];
      longint cur_cell [3];
      longint tmx [3];
      longint dl [3];
      longint t, frac, mag, bnd_dist, s;
      int     ax, last, ci, addr;
      logic [7:0] hit;
      logic [1:0] st;
      p[0] = px; p[1] = py; p[2] = pz;
      d[0] = dx; d[1] = dy; d[2] = dz;
      t = 0; last = -1; hit = 8'd0; st = ST_MAXD;
      for (int a = 0; a < 3; a++) begin
         cur_cell[a] = p[a] >>> 16;
         frac = p[a] - cur_cell[a] * 65536;
         mag = d[a] < 0 ? -d[a] : d[a];
         if (mag == 0) begin
            tmx[a] = T_NEVER;
            dl[a] = T_NEVER;
         end else begin
            bnd_dist = d[a] > 0 ? 65536 - frac : frac;
            dl[a] = (64'sd1 <<< 31) / mag;
            tmx[a] = (bnd_dist <<< 15) / mag;
         end
      end
      forever begin
         if (!find_cell(cur_cell[0], cur_cell[1], cur_cell[2], ci, addr) || !chunk_on[ci])
         begin
            st = ST_OUT;
            break;
         end
         hit = voxel_mem[addr];
         if (hit != 0) begin
            st = ST_HIT;
            break;
         end
         if (tmx[0] < tmx[1]) ax = tmx[0] < tmx[2] ? 0 : 2;
         else ax = tmx[1] < tmx[2] ? 1 : 2;
         if (tmx[ax] > maxd) begin
            st = ST_MAXD;
            t = maxd;
            last = -1;
            break;
         end
         cur_cell[ax] += d[ax] > 0 ? 1 : -1;
         t = tmx[ax];
         tmx[ax] += dl[ax];
         last = ax;
      end
      w.status = st;
      w.hit = hit;
      w.cx = cur_cell[0][15:0];
      w.cy = cur_cell[1][15:0];
      w.cz = cur_cell[2][15:0];
      w.axis = last == 0 ? AX_X : last == 1 ? AX_Y : last == 2 ? AX_Z : AX_NONE;
      w.neg = last >= 0 && d[last] > 0;
      for (int a = 0; a < 3; a++) begin
         s = p[a] + ((t * d[a]) >>> 15);
         if (s > 64'sd2147483647) s = 64'sd2147483647;
         if (s < -64'sd2147483648) s = -64'sd2147483648;
         if (a == 0) w.ex = s[31:0];
         else if (a == 1) w.ey = s[31:0];
         else w.ez = s[31:0];
      end
      w.t = t[30:0];
      return w;
   endfunction

   task automatic report(input string field, input logic [31:0] got, want);
      $display("mismatch %s: got %0h, expected %0h at %0t", field, got, want, $realtime);
      fail_count++;
   endtask

   task automatic cmp(input string field, input logic [31:0] got, want);
      if (got !== want) report(field, got, want);
   endtask

   always @(posedge clock) begin
      int           ci, addr;
      ray_word_type w;
      if (!reset && csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ORG_X: org[0] = longint'($signed(csr_wdata));
            CSR_ORG_Y: org[1] = longint'($signed(csr_wdata));
            CSR_ORG_Z: org[2] = longint'($signed(csr_wdata));
            default: ;
         endcase
      end
      if (!reset && start && !busy) begin
         case (req_kind)
            KIND_WRITE: begin
               if (find_cell(req_pos_x >>> 16, req_pos_y >>> 16, req_pos_z >>> 16, ci, addr)
                   && chunk_on[ci])
                  voxel_mem[addr] = req_voxel_value;
            end
            KIND_LOAD: begin
               if (find_cell(req_pos_x >>> 16, req_pos_y >>> 16, req_pos_z >>> 16, ci, addr))
                  chunk_on[ci] = req_loaded_flag;
            end
            KIND_RAY:
               ray_q.push_back(walk_ray(req_pos_x, req_pos_y, req_pos_z, req_dir_x, req_dir_y,
                                        req_dir_z, longint'(req_max_distance)));
            default: ;
         endcase
      end
      if (!reset && rsp_valid) begin
         if (ray_q.size() == 0) begin
            report("unexpected word", 32'd0, 32'd0);
         end else begin
            w = ray_q.pop_front();
            cmp("status", rsp_status, w.status);
            cmp("hit_value", rsp_hit_value, w.hit);
            cmp("cell_x", rsp_cell_x, w.cx);
            cmp("cell_y", rsp_cell_y, w.cy);
            cmp("cell_z", rsp_cell_z, w.cz);
            cmp("normal_axis", rsp_normal_axis, w.axis);
            cmp("normal_negative", rsp_normal_negative, w.neg);
            cmp("end_x", rsp_end_x, w.ex);
            cmp("end_y", rsp_end_y, w.ey);
            cmp("end_z", rsp_end_z, w.ez);
            cmp("ray_param", rsp_ray_param, w.t);
         end
      end
   end

endmodule

[sim/voxel_grid_ray_traversal_tb.sv]
// ---------------------------------------------------------------------------
// voxel_grid_ray_traversal_tb: testbench top
// Drives voxel writes, chunk loads and rays over several window origins,
// with random start gaps; the checker predicts and compares every word.
// ---------------------------------------------------------------------------
module voxel_grid_ray_traversal_tb;
   import vgrt_pkg::*;

   localparam logic [1:0] KIND_NOP = 2'd3;
   localparam int LIMIT = 8000000;
   localparam int PHASE_ITEMS = 200;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_kind = KIND_NOP;
   logic signed [31:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic signed [15:0] req_dir_x = '0, req_dir_y = '0, req_dir_z = '0;
   logic [30:0]        req_max_distance = '0;
   logic [7:0]         req_voxel_value = '0;
   logic               req_loaded_flag = 1'b0;
   logic               rsp_valid;
   logic [1:0]         rsp_status;
   logic [7:0]         rsp_hit_value;
   logic signed [15:0] rsp_cell_x, rsp_cell_y, rsp_cell_z;
   logic [1:0]         rsp_normal_axis;
   logic               rsp_normal_negative;
   logic signed [31:0] rsp_end_x, rsp_end_y, rsp_end_z;
   logic [30:0]        rsp_ray_param;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index = CSR_ORG_X;
   logic [11:0]        csr_wdata = '0;
   int                 fail_count, pending;
   int                 cycles = 0;
   bit                 idle_en = 1'b1;
   int                 base [3];

   always #5 clock = ~clock;

   voxel_grid_ray_traversal uut (.*);
   voxel_grid_ray_traversal_chk chk (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Present one word and hold it until taken.
   task automatic send(input logic [1:0] kind, input logic [31:0] px, py, pz,
                       input logic [15:0] dx, dy, dz, input logic [30:0] maxd,
                       input logic [7:0] val, input logic flag);
      if (idle_en && $urandom_range(0, 99) < 15) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start <= 1'b1;
      req_kind <= kind;
      req_pos_x <= px; req_pos_y <= py; req_pos_z <= pz;
      req_dir_x <= dx; req_dir_y <= dy; req_dir_z <= dz;
      req_max_distance <= maxd;
      req_voxel_value <= val;
      req_loaded_flag <= flag;
      do @(posedge clock); while (busy);
   endtask

   // Drop start and wait until every ray word is back and the block is idle.
   task automatic drain;
      start <= 1'b0;
      do @(posedge clock); while (pending != 0 || busy);
      repeat (12) @(posedge clock);
   endtask

   // Leave valid high; the caller drops it after the last write.
   task automatic csr_write(input logic [1:0] idx, input logic [11:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic set_origin(input logic [11:0] ox, oy, oz);
      csr_write(CSR_ORG_X, ox);
      csr_write(CSR_ORG_Y, oy);
      csr_write(CSR_ORG_Z, oz);
      csr_valid <= 1'b0;
      base[0] = $signed(ox) * CHUNK_SIDE;
      base[1] = $signed(oy) * CHUNK_SIDE;
      base[2] = $signed(oz) * CHUNK_SIDE;
      @(posedge clock);
   endtask

   function automatic logic [31:0] at_cell(input int c);
      return {c[15:0], 16'h8000};
   endfunction

   // Position in the window, now and then just outside it.
   function automatic logic [31:0] win_pos(input int a);
      int c;
      if ($urandom_range(0, 9) == 0) c = base[a] + $urandom_range(0, 79) - 8;
      else c = base[a] + $urandom_range(0, 63);
      return {c[15:0], 16'($urandom)};
   endfunction

   function automatic logic [15:0] rand_dir;
      case ($urandom_range(0, 9))
         0: return 16'h0000;
         1: return 16'h8000;
         2: return 16'h7fff;
         3: return $urandom_range(0, 1) ? 16'($urandom_range(1, 64)) : -16'($urandom_range(1, 64));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [30:0] rand_maxd;
      case ($urandom_range(0, 5))
         0: return 31'd0;
         1: return 31'($urandom);
         default: return 31'($urandom_range(0, 80 << 16));
      endcase
   endfunction

   task automatic random_item;
      int r;
      r = $urandom_range(0, 99);
      if (r < 12)
         send(KIND_LOAD, win_pos(0), win_pos(1), win_pos(2), rand_dir(), rand_dir(),
              rand_dir(), rand_maxd(), 8'($urandom), $urandom_range(0, 99) < 85);
      else if (r < 42)
         send(KIND_WRITE, win_pos(0), win_pos(1), win_pos(2), rand_dir(), rand_dir(),
              rand_dir(), rand_maxd(), $urandom_range(0, 9) < 4 ? 8'd0 : 8'($urandom),
              1'($urandom));
      else if (r < 88)
         send(KIND_RAY, win_pos(0), win_pos(1), win_pos(2), rand_dir(), rand_dir(),
              rand_dir(), rand_maxd(), 8'($urandom), 1'($urandom));
      else
         send(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom, 16'($urandom),
              16'($urandom), 16'($urandom), 31'($urandom), 8'($urandom), 1'($urandom));
   endtask

   initial begin
      logic [11:0] orgs [7][3];
      orgs[0] = '{12'd0, 12'd0, 12'd0};
      orgs[1] = '{12'h800, 12'h800, 12'h800};
      orgs[2] = '{12'h7ff, 12'h7ff, 12'h7ff};
      orgs[3] = '{12'hfff, 12'd0, 12'd1};
      orgs[4] = '{12'h800, 12'h7ff, 12'hffe};
      orgs[5] = '{12'($urandom), 12'($urandom), 12'($urandom)};
      orgs[6] = '{12'd2, 12'hffd, 12'd0};

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      set_origin(12'd0, 12'd0, 12'd0);
      // clearing pass holds busy; send waits it out

      // unloaded start cell
      send(KIND_RAY, at_cell(1), at_cell(1), at_cell(1), 16'h7fff, 0, 0, 31'h7fffffff, 0, 0);
      send(KIND_LOAD, at_cell(0), at_cell(0), at_cell(0), 0, 0, 0, 0, 0, 1'b1);
      send(KIND_LOAD, at_cell(-1), at_cell(0), at_cell(0), 0, 0, 0, 0, 0, 1'b1);
      send(KIND_WRITE, at_cell(20), at_cell(1), at_cell(1), 0, 0, 0, 0, 8'd7, 0);
      send(KIND_WRITE, at_cell(5), at_cell(1), at_cell(1), 0, 0, 0, 0, 8'd255, 0);
      send(KIND_RAY, at_cell(1), at_cell(1), at_cell(1), 16'h7fff, 0, 0, 31'h7fffffff, 0, 0);
      send(KIND_RAY, at_cell(1), at_cell(1), at_cell(1), 16'h8000, 0, 0, 31'h7fffffff, 0, 0);
      send(KIND_RAY, at_cell(1), at_cell(1), at_cell(1), 0, 0, 0, 31'd1000, 0, 0);
      send(KIND_RAY, at_cell(1), at_cell(1), at_cell(1), 16'd100, 16'd5, 0, 31'd0, 0, 0);
      // equal components: ties go to z, then y
      send(KIND_RAY, at_cell(2), at_cell(2), at_cell(2), 16'h4000, 16'h4000, 16'h4000,
           31'h7fffffff, 0, 0);
      send(KIND_RAY, at_cell(2), at_cell(2), at_cell(2), 16'hc000, 16'h4000, 16'hc000,
           31'd600000, 0, 0);
      send(KIND_LOAD, at_cell(3), at_cell(3), at_cell(3), 0, 0, 0, 0, 0, 1'b0);
      send(KIND_RAY, at_cell(1), at_cell(1), at_cell(1), 16'h7fff, 0, 0, 31'h7fffffff, 0, 0);
      send(KIND_LOAD, at_cell(3), at_cell(3), at_cell(3), 0, 0, 0, 0, 0, 1'b1);
      send(KIND_RAY, at_cell(1), at_cell(1), at_cell(1), 16'h7fff, 0, 0, 31'h7fffffff, 0, 0);
      send(KIND_NOP, at_cell(5), at_cell(1), at_cell(1), 0, 0, 0, 0, 8'd0, 1'b0);
      send(KIND_WRITE, 32'h80000000, 32'h7fffffff, 32'h0, 0, 0, 0, 0, 8'd9, 1'b1);
      send(KIND_RAY, 32'h80000000, 32'h7fffffff, 32'h0, 16'h8000, 16'h7fff, 16'h8000,
           31'h7fffffff, 0, 0);
      send(KIND_RAY, 32'h0000ffff, 32'h00000000, 32'h0000ffff, 16'h8000, 16'h8000, 16'h7fff,
           31'd300000, 0, 0);
      send(KIND_WRITE, at_cell(5), at_cell(1), at_cell(1), 0, 0, 0, 0, 8'd0, 0);
      send(KIND_RAY, at_cell(1), at_cell(1), at_cell(1), 16'h7fff, 16'h0100, 0,
           31'h7fffffff, 0, 0);
      drain();

      for (int ph = 0; ph < 7; ph++) begin
         set_origin(orgs[ph][0], orgs[ph][1], orgs[ph][2]);
         idle_en = ph != 3;
         // open the phase with a burst of loads so writes and rays get far
         for (int i = 0; i < 20; i++)
            send(KIND_LOAD, win_pos(0), win_pos(1), win_pos(2), 0, 0, 0, 0, 0,
                 $urandom_range(0, 9) != 0);
         for (int i = 0; i < PHASE_ITEMS; i++) random_item();
         drain();
      end

      if (fail_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
